// ----- hdl/integer_alu_with_divide_defines.svh -----
// ----------------------------------------------------------------------------
// integer alu with divide: assertion macros
// shared property wrappers clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_WITH_DIVIDE_DEFINES_SVH
`define INTEGER_ALU_WITH_DIVIDE_DEFINES_SVH

// consequent checked in the same cycle
`define IALU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define IALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ialu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_pkg
// operation codes and pipeline control types for the integer alu
// ----------------------------------------------------------------------------
package ialu_pkg;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_REM = 4'd4,
    MODE_SHL = 4'd5,
    MODE_SAR = 4'd6,
    MODE_AND = 4'd7,
    MODE_OR  = 4'd8,
    MODE_XOR = 4'd9,
    MODE_NOT = 4'd10
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  is_rem;
    logic  q_neg;
    logic  r_neg;
    logic  dz;
  } meta_t;

endpackage

// ----- hdl/ialu_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_prep
// input stage: decodes the operation, computes add, sub, shift and logic results and
// loads multiply and divide operands for the cell chain
// ----------------------------------------------------------------------------
module ialu_prep import ialu_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  input  logic [3:0]                   mode_i,
  output logic                         valid_o,
  output meta_t                        meta_o,
  output logic [DATA_WIDTH-1:0]        acc_o,
  output logic [DATA_WIDTH-1:0]        x_o,
  output logic [DATA_WIDTH-1:0]        y_o
);

  logic                  valid_q;
  meta_t                 meta_d, meta_q;
  logic [DATA_WIDTH-1:0] acc_d, acc_q, x_d, x_q, y_d, y_q;
  logic [DATA_WIDTH-1:0] a_u, b_u, mag_a, mag_b;
  logic                  a_neg, b_neg;
  logic [4:0]            sh;

  assign a_u   = operand_a_i;
  assign b_u   = operand_b_i;
  assign a_neg = a_u[DATA_WIDTH-1];
  assign b_neg = b_u[DATA_WIDTH-1];
  assign mag_a = a_neg ? (~a_u + DATA_WIDTH'(1)) : a_u;
  assign mag_b = b_neg ? (~b_u + DATA_WIDTH'(1)) : b_u;
  assign sh    = b_u[4:0];

  always_comb begin
    meta_d = '{kind: KIND_PASS, is_rem: 1'b0, q_neg: 1'b0, r_neg: 1'b0, dz: 1'b0};
    acc_d  = '0;
    x_d    = '0;
    y_d    = '0;
    unique case (mode_e'(mode_i)) inside
      MODE_ADD: acc_d = a_u + b_u;
      MODE_SUB: acc_d = a_u - b_u;
      MODE_MUL: begin
        meta_d.kind = KIND_MUL;
        x_d         = b_u;
        y_d         = a_u;
      end
      MODE_DIV, MODE_REM: begin
        if (b_u == '0) begin
          meta_d.dz = 1'b1;
        end else begin
          meta_d.kind   = KIND_DIV;
          meta_d.is_rem = (mode_e'(mode_i) == MODE_REM);
          meta_d.q_neg  = a_neg ^ b_neg;
          meta_d.r_neg  = a_neg;
          x_d           = mag_a;
          y_d           = mag_b;
        end
      end
      MODE_SHL: acc_d = a_u << sh;
      MODE_SAR: acc_d = operand_a_i >>> sh;
      MODE_AND: acc_d = a_u & b_u;
      MODE_OR:  acc_d = a_u | b_u;
      MODE_XOR: acc_d = a_u ^ b_u;
      MODE_NOT: acc_d = ~a_u;
      default:  acc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q <= meta_d;
      acc_q  <= acc_d;
      x_q    <= x_d;
      y_q    <= y_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign acc_o   = acc_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

// ----- hdl/ialu_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_cell
// one step of the shared chain: a shift-add multiply step or a restoring
// divide step, other transactions pass unchanged
// ----------------------------------------------------------------------------
module ialu_cell import ialu_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  meta_t                 meta_i,
  input  logic [DATA_WIDTH-1:0] acc_i,
  input  logic [DATA_WIDTH-1:0] x_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  output logic                  valid_o,
  output meta_t                 meta_o,
  output logic [DATA_WIDTH-1:0] acc_o,
  output logic [DATA_WIDTH-1:0] x_o,
  output logic [DATA_WIDTH-1:0] y_o
);

  logic                  valid_q;
  meta_t                 meta_q;
  logic [DATA_WIDTH-1:0] acc_d, acc_q, x_d, x_q, y_d, y_q;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, acc_i, x_i[DATA_WIDTH-1]} - {2'b00, y_i};
  assign fits = ~diff[DATA_WIDTH+1];

  always_comb begin
    acc_d = acc_i;
    x_d   = x_i;
    y_d   = y_i;
    unique case (meta_i.kind)
      KIND_MUL: begin
        acc_d = x_i[0] ? (acc_i + y_i) : acc_i;
        x_d   = x_i >> 1;
        y_d   = y_i << 1;
      end
      KIND_DIV: begin
        acc_d = fits ? diff[DATA_WIDTH-1:0] : {acc_i[DATA_WIDTH-2:0], x_i[DATA_WIDTH-1]};
        x_d   = {x_i[DATA_WIDTH-2:0], fits};
      end
      default: begin
        acc_d = acc_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q <= meta_i;
      acc_q  <= acc_d;
      x_q    <= x_d;
      y_q    <= y_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign acc_o   = acc_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

// ----- hdl/integer_alu_with_divide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_with_divide
// signed integer alu with add, sub, mul, div, rem, shifts and logic ops,
// built as an input stage, a chain of DATA_WIDTH step cells and a result stage
// ----------------------------------------------------------------------------
// channel  | handshake               | payload
// input    | in_valid_i / in_stall_o | operand_a_i, operand_b_i, mode_i
// output   | out_valid_o / out_stall_i | result_o, divide_by_zero_o
//
// every operation takes all stages; one transaction per cycle unless a full chain stalls
// each chain cell does one multiplier bit or one quotient bit
// reset clears the stage valid bits only, no clearing pass
// a stall on the output holds only full stages, bubbles still close up
// ----------------------------------------------------------------------------
`include "integer_alu_with_divide_defines.svh"

module integer_alu_with_divide import ialu_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  input  logic [3:0]                   mode_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic                         divide_by_zero_o
);

  logic [DATA_WIDTH+1:0] stage_valid;
  logic [DATA_WIDTH+1:0] stage_en;
  meta_t                 meta [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] acc  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] xr   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] yr   [DATA_WIDTH+1];

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] result_d, result_q;
  logic                  dz_q;
  meta_t                 last;

  assign stage_valid[DATA_WIDTH+1] = out_valid_q;
  assign stage_en[DATA_WIDTH+1]    = ~out_valid_q | ~out_stall_i;

  for (genvar s = 0; s <= DATA_WIDTH; s++) begin : g_en
    assign stage_en[s] = ~stage_valid[s] | stage_en[s+1];
  end

  assign in_stall_o = ~stage_en[0];

  ialu_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk_i,
    .rst_ni,
    .en_i       (stage_en[0]),
    .valid_i    (in_valid_i),
    .operand_a_i,
    .operand_b_i,
    .mode_i,
    .valid_o    (stage_valid[0]),
    .meta_o     (meta[0]),
    .acc_o      (acc[0]),
    .x_o        (xr[0]),
    .y_o        (yr[0])
  );

  for (genvar k = 1; k <= DATA_WIDTH; k++) begin : g_cell
    ialu_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (stage_en[k]),
      .valid_i (stage_valid[k-1]),
      .meta_i  (meta[k-1]),
      .acc_i   (acc[k-1]),
      .x_i     (xr[k-1]),
      .y_i     (yr[k-1]),
      .valid_o (stage_valid[k]),
      .meta_o  (meta[k]),
      .acc_o   (acc[k]),
      .x_o     (xr[k]),
      .y_o     (yr[k])
    );
  end

  assign last = meta[DATA_WIDTH];

  // sign fix of quotient and remainder
  always_comb begin
    unique case (last.kind)
      KIND_DIV: begin
        if (last.is_rem) begin
          result_d = last.r_neg ? (~acc[DATA_WIDTH] + DATA_WIDTH'(1)) : acc[DATA_WIDTH];
        end else begin
          result_d = last.q_neg ? (~xr[DATA_WIDTH] + DATA_WIDTH'(1)) : xr[DATA_WIDTH];
        end
      end
      default: result_d = acc[DATA_WIDTH];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_en[DATA_WIDTH+1]) begin
      out_valid_q <= stage_valid[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[DATA_WIDTH+1]) begin
      result_q <= result_d;
      dz_q     <= last.dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = result_q;
  assign divide_by_zero_o = dz_q;

  `IALU_ASSERT_SAME(a_dz_zero, out_valid_o && divide_by_zero_o, result_o == '0, "divide by zero result not zero")
  `IALU_ASSERT_SAME(a_stall_full, in_stall_o, &stage_valid, "input stalled with a bubble in the chain")
  `IALU_ASSERT_NEXT(a_accept_loads, in_valid_i && !in_stall_o, stage_valid[0], "accepted transaction not loaded")

endmodule
